// ===== design/toy_isa_instruction_executor_assert.svh =====
// Assertion macros shared by the executor modules
`ifndef TOY_ISA_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define TOY_ISA_INSTRUCTION_EXECUTOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define TIE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define TIE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/tie_pkg.sv =====
// Package: types, opcodes and helpers for the instruction executor
`timescale 1ns / 1ps
package tie_pkg;
  localparam int NUM_REGS_DEF  = 16;
  localparam int MEM_BYTES_DEF = 4096;

  localparam logic [7:0] OP_SET    = 8'h00;
  localparam logic [7:0] OP_ADD    = 8'h10;
  localparam logic [7:0] OP_ADDI   = 8'h11;
  localparam logic [7:0] OP_SUB    = 8'h20;
  localparam logic [7:0] OP_SUBI   = 8'h21;
  localparam logic [7:0] OP_MUL    = 8'h30;
  localparam logic [7:0] OP_MULI   = 8'h31;
  localparam logic [7:0] OP_DIV    = 8'h40;
  localparam logic [7:0] OP_DIVI   = 8'h41;
  localparam logic [7:0] OP_LOAD   = 8'h50;
  localparam logic [7:0] OP_LOADR  = 8'h51;
  localparam logic [7:0] OP_STORE  = 8'h60;
  localparam logic [7:0] OP_STORER = 8'h61;
  localparam logic [7:0] OP_RET    = 8'h70;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] target_index;
    logic [7:0] field_b;
    logic [7:0] field_c;
  } tie_in_t;

  typedef struct packed {
    logic              reg_written;
    logic [7:0]        written_index;
    logic signed [31:0] written_value;
    logic              halted;
    logic              fault;
  } tie_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_B, ST_RD_C, ST_RD_T, ST_CHECK, ST_DIV,
    ST_MEM, ST_WRITE, ST_DONE
  } tie_state_t;

  // shared unit operation
  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV} tie_alu_op_t;

  // sequencer to arithmetic unit
  typedef struct packed {
    logic        start;
    tie_alu_op_t op;
  } tie_alu_ctl_t;

  // arithmetic unit status
  typedef struct packed {
    logic busy;
    logic done;
  } tie_alu_sts_t;
endpackage

// ===== design/tie_alu.sv =====
// Shared arithmetic unit: registered add/sub/mul, radix-2 signed divider
`timescale 1ns / 1ps
`include "toy_isa_instruction_executor_assert.svh"
module tie_alu
  import tie_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  tie_alu_ctl_t ctl,
  input  logic [31:0]  opa,
  input  logic [31:0]  opb,
  output tie_alu_sts_t sts,
  output logic [31:0]  res
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;
  logic [31:0] res_r, res_nxt;
  logic [32:0] trial;
  logic [31:0] ma, mb;

  // magnitudes for the divider
  assign ma = opa[31] ? (32'd0 - opa) : opa;
  assign mb = opb[31] ? (32'd0 - opb) : opb;
  assign trial = {rem_r, quo_r[31]} - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    res_nxt  = res_r;
    if (ctl.start) begin
      unique case (ctl.op)
        ALU_ADD: begin res_nxt = opa + opb; done_nxt = 1'b1; end
        ALU_SUB: begin res_nxt = opa - opb; done_nxt = 1'b1; end
        ALU_MUL: begin res_nxt = opa * opb; done_nxt = 1'b1; end
        ALU_DIV: begin
          busy_nxt = 1'b1;
          cnt_nxt  = 6'd0;
          rem_nxt  = 32'd0;
          quo_nxt  = ma;
          dsr_nxt  = mb;
          neg_nxt  = opa[31] ^ opb[31];
          zero_nxt = (opb == 32'd0);
        end
        default: ;
      endcase
    end else if (busy_r) begin
      // one quotient bit a cycle
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = zero_r ? 32'd0 : (neg_r ? (32'd0 - quo_nxt) : quo_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dsr_r  <= dsr_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    res_r  <= res_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = res_r;

  `TIE_ASSERT_IMP(a_no_start_busy, clk, rst_n, busy_r, !ctl.start, "start while dividing")
  `TIE_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r, "done while busy")
  `TIE_ASSERT_NXT(a_div_done, clk, rst_n, busy_r && cnt_r == 6'd31, done_r, "divide lost")
endmodule

// ===== design/toy_isa_instruction_executor.sv =====
// Top level: sequencer, register file, data memory and shared arithmetic unit
// Each request passes RD_B, RD_C, RD_T and CHECK. One that does no work (return,
// faults found at decode, unknown opcode, any request after halt) then goes to
// DONE; a set passes WRITE, a memory address fault passes MEM. Add, sub, mul and
// divide wait in DIV for the arithmetic unit and then pass WRITE; a store writes
// and a load reads one memory byte a cycle in MEM, the load then passes WRITE. The
// radix-2 divider gives one quotient bit per iteration for all 32 quotient bits.
// Each result waits in DONE until out_ready. The block takes no request while
// one is being executed or its result waits. After reset a clearing pass zeroes
// every byte of the data memory before the first request is taken.
`timescale 1ns / 1ps
`include "toy_isa_instruction_executor_assert.svh"
module toy_isa_instruction_executor
  import tie_pkg::*;
#(
  parameter int NUM_REGS  = NUM_REGS_DEF,
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tie_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tie_out_t out_data
);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int AW = $clog2(MEM_BYTES);

  // register file: reads at one address a cycle, valid bits give reset zero
  logic [31:0] rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_r;
  logic [31:0] rf_q_r;
  logic [7:0]  rf_raddr;
  logic        rf_we;
  logic [7:0]  rf_waddr;
  logic [31:0] rf_wdata;

  // data memory, one byte a cycle
  logic [7:0]  dm [MEM_BYTES];
  logic [7:0]  dm_q_r;
  logic        dm_we;
  logic [AW-1:0] dm_addr;
  logic [7:0]  dm_wdata;

  tie_state_t st_r, st_nxt;
  tie_in_t    ins_r, ins_nxt;
  logic [31:0] x_r, x_nxt, y_r, y_nxt, t_r, t_nxt;
  logic [31:0] val_r, val_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [2:0]  bcnt_r, bcnt_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic        halt_r, halt_nxt;
  tie_out_t    out_r, out_nxt;
  logic        ovld_r, ovld_nxt;
  tie_alu_ctl_t alu_ctl;
  tie_alu_sts_t alu_sts;
  logic [31:0] alu_res;
  logic [31:0] alu_b;

  logic [3:0] grp;
  logic       imm_form;
  logic       bad_t, bad_b, bad_c;
  logic [32:0] addr_end;

  assign grp      = ins_r.opcode[7:4];
  assign imm_form = ins_r.opcode[0];
  assign bad_t    = ({24'd0, ins_r.target_index} >= NUM_REGS);
  assign bad_b    = ({24'd0, ins_r.field_b} >= NUM_REGS);
  assign bad_c    = ({24'd0, ins_r.field_c} >= NUM_REGS);
  assign addr_end = {1'b0, addr_r} + 33'd4;
  assign alu_b    = imm_form ? {24'd0, ins_r.field_c} : y_r;

  tie_alu u_alu (
    .clk (clk), .rst_n (rst_n), .ctl (alu_ctl), .opa (x_r), .opb (alu_b),
    .sts (alu_sts), .res (alu_res)
  );

  // register file access
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_waddr[RW-1:0]] <= rf_wdata;
    rf_q_r <= rf_vld_r[rf_raddr[RW-1:0]] ? rf_mem[rf_raddr[RW-1:0]] : 32'd0;
  end

  // data memory access
  always_ff @(posedge clk) begin
    if (dm_we) dm[dm_addr] <= dm_wdata;
    dm_q_r <= dm[dm_addr];
  end

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    ins_nxt   = ins_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    t_nxt     = t_r;
    val_nxt   = val_r;
    addr_nxt  = addr_r;
    bcnt_nxt  = bcnt_r;
    clr_nxt   = clr_r;
    halt_nxt  = halt_r;
    out_nxt   = out_r;
    ovld_nxt  = ovld_r;
    in_ready  = 1'b0;
    rf_raddr  = ins_r.field_b;
    rf_we     = 1'b0;
    rf_waddr  = ins_r.target_index;
    rf_wdata  = val_r;
    dm_we     = 1'b0;
    dm_addr   = addr_r[AW-1:0] + AW'(bcnt_r);
    dm_wdata  = t_r[8*bcnt_r[1:0] +: 8];
    alu_ctl.start = 1'b0;
    alu_ctl.op    = tie_alu_op_t'(grp[1:0] - 2'd1);
    unique case (st_r)
      ST_CLEAR: begin
        dm_we    = 1'b1;
        dm_addr  = clr_r[AW-1:0];
        dm_wdata = 8'd0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == (AW+1)'(MEM_BYTES - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ins_nxt = in_data;
          st_nxt  = ST_RD_B;
        end
      end
      ST_RD_B: begin
        rf_raddr = ins_r.field_b;
        st_nxt   = ST_RD_C;
      end
      ST_RD_C: begin
        rf_raddr = ins_r.field_c;
        x_nxt    = rf_q_r;
        st_nxt   = ST_RD_T;
      end
      ST_RD_T: begin
        rf_raddr = ins_r.target_index;
        y_nxt    = rf_q_r;
        st_nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        t_nxt    = rf_q_r;
        addr_nxt = imm_form ? (x_r + y_r) : {16'd0, ins_r.field_b, ins_r.field_c};
        bcnt_nxt = 3'd0;
        val_nxt  = 32'd0;
        out_nxt  = '0;
        st_nxt   = ST_DONE;
        if (!halt_r) begin
          priority if (ins_r.opcode == OP_SET) begin
            if (bad_t) out_nxt.fault = 1'b1;
            else begin
              val_nxt = {16'd0, ins_r.field_b, ins_r.field_c};
              st_nxt  = ST_WRITE;
            end
          end else if ((grp >= 4'h1) && (grp <= 4'h4) && (ins_r.opcode[3:1] == 3'd0)) begin
            if (bad_t || bad_b || (!imm_form && bad_c)) out_nxt.fault = 1'b1;
            else begin
              alu_ctl.start = 1'b1;
              st_nxt = ST_DIV;
            end
          end else if ((grp == 4'h5 || grp == 4'h6) && (ins_r.opcode[3:1] == 3'd0)) begin
            if (bad_t || (imm_form && (bad_b || bad_c))) out_nxt.fault = 1'b1;
            else st_nxt = ST_MEM;
          end else if (ins_r.opcode == OP_RET) begin
            halt_nxt = 1'b1;
          end else begin
            st_nxt = ST_DONE;
          end
        end
        out_nxt.halted = halt_nxt;
        if (st_nxt == ST_DONE) ovld_nxt = 1'b1;
      end
      ST_DIV: begin
        if (alu_sts.done) begin
          val_nxt = alu_res;
          st_nxt  = ST_WRITE;
        end
      end
      ST_MEM: begin
        // address range check, then one byte a cycle
        if (addr_end > 33'(MEM_BYTES)) begin
          out_nxt.fault = 1'b1;
          ovld_nxt = 1'b1;
          st_nxt   = ST_DONE;
        end else if (grp == 4'h6) begin
          dm_we    = 1'b1;
          bcnt_nxt = bcnt_r + 3'd1;
          if (bcnt_r == 3'd3) begin
            ovld_nxt = 1'b1;
            st_nxt   = ST_DONE;
          end
        end else begin
          bcnt_nxt = bcnt_r + 3'd1;
          if (bcnt_r != 3'd0) val_nxt = {dm_q_r, val_r[31:8]};
          if (bcnt_r == 3'd4) st_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        rf_we    = 1'b1;
        out_nxt.reg_written   = 1'b1;
        out_nxt.written_index = ins_r.target_index;
        out_nxt.written_value = val_r;
        ovld_nxt = 1'b1;
        st_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (ovld_r && out_ready) begin
          ovld_nxt = 1'b0;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLEAR;
      clr_r    <= '0;
      halt_r   <= 1'b0;
      ovld_r   <= 1'b0;
      rf_vld_r <= '0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      halt_r <= halt_nxt;
      ovld_r <= ovld_nxt;
      if (rf_we) rf_vld_r[rf_waddr[RW-1:0]] <= 1'b1;
    end
    ins_r  <= ins_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    t_r    <= t_nxt;
    val_r  <= val_nxt;
    addr_r <= addr_nxt;
    bcnt_r <= bcnt_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = ovld_r;
  assign out_data  = out_r;

  `TIE_ASSERT_IMP(a_out_in_done, clk, rst_n, ovld_r, st_r == ST_DONE, "result outside done")
  `TIE_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !ovld_r, "ready with pending result")
  `TIE_ASSERT_NXT(a_halt_sticky, clk, rst_n, halt_r, halt_r, "halt flag cleared")
endmodule

// ===== tb/tie_checker.sv =====
// Checker for the instruction executor: predicts each result and compares it
`timescale 1ns / 1ps
module tie_checker
  import tie_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  tie_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  tie_out_t out_data,
  output int       fail_count,
  output int       pending
);
  logic [31:0] regs [NUM_REGS_DEF];
  logic [7:0]  mem [MEM_BYTES_DEF];
  logic        halt_q;
  tie_out_t    expected_q [$];

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    if (mb == 0) return 0;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic reg_ok(logic [7:0] i);
    return i < NUM_REGS_DEF;
  endfunction

  // execute one request against the shadow state
  task automatic execute(tie_in_t r);
    tie_out_t    res;
    logic [31:0] x, y, addr, v;
    logic [15:0] imm;
    logic        wr, flt;
    wr = 0; flt = 0; v = 0;
    imm = {r.field_b, r.field_c};
    if (!halt_q) begin
      case (r.opcode)
        OP_SET: begin
          if (!reg_ok(r.target_index)) flt = 1;
          else begin
            v = {16'd0, imm}; wr = 1;
          end
        end
        OP_ADD, OP_ADDI, OP_SUB, OP_SUBI, OP_MUL, OP_MULI, OP_DIV, OP_DIVI: begin
          if (!reg_ok(r.target_index) || !reg_ok(r.field_b) ||
              (!r.opcode[0] && !reg_ok(r.field_c))) flt = 1;
          else begin
            x = regs[r.field_b];
            y = r.opcode[0] ? {24'd0, r.field_c} : regs[r.field_c];
            case (r.opcode & 8'hF0)
              OP_ADD:  v = x + y;
              OP_SUB:  v = x - y;
              OP_MUL:  v = x * y;
              default: v = sdiv(x, y);
            endcase
            wr = 1;
          end
        end
        OP_LOAD, OP_LOADR, OP_STORE, OP_STORER: begin
          if (!reg_ok(r.target_index) ||
              (r.opcode[0] && (!reg_ok(r.field_b) || !reg_ok(r.field_c)))) flt = 1;
          else begin
            addr = r.opcode[0] ? regs[r.field_b] + regs[r.field_c] : {16'd0, imm};
            if ({1'b0, addr} + 33'd4 > MEM_BYTES_DEF) flt = 1;
            else if ((r.opcode & 8'hF0) == OP_LOAD) begin
              v = {mem[addr+3], mem[addr+2], mem[addr+1], mem[addr]};
              wr = 1;
            end else begin
              for (int k = 0; k < 4; k++) mem[addr+k] = regs[r.target_index][8*k +: 8];
            end
          end
        end
        OP_RET: halt_q = 1;
        default: ;
      endcase
      if (wr) regs[r.target_index] = v;
    end
    res.reg_written   = wr;
    res.written_index = wr ? r.target_index : 8'd0;
    res.written_value = wr ? v : 32'd0;
    res.halted        = halt_q;
    res.fault         = flt;
    expected_q.push_back(res);
  endtask

  task automatic report(string what, tie_out_t got, tie_out_t exp);
    $display("mismatch %s: got %p expected %p", what, got, exp);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    halt_q = 0;
    foreach (regs[i]) regs[i] = 0;
    foreach (mem[i]) mem[i] = 0;
  end

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    tie_out_t e;
    if (rst_n) begin
      if (in_valid && in_ready) execute(in_data);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) report("unexpected result", out_data, out_data);
        else begin
          e = expected_q.pop_front();
          if (out_data.reg_written !== e.reg_written) report("reg_written", out_data, e);
          if (out_data.written_index !== e.written_index)
            report("written_index", out_data, e);
          if (out_data.written_value !== e.written_value)
            report("written_value", out_data, e);
          if (out_data.halted !== e.halted) report("halted", out_data, e);
          if (out_data.fault !== e.fault) report("fault", out_data, e);
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

// ===== tb/tb_toy_isa_instruction_executor.sv =====
// Testbench top: stimulus, result back-pressure and verdict for the executor
`timescale 1ns / 1ps
module tb_toy_isa_instruction_executor;
  import tie_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  tie_in_t  in_data;
  tie_out_t out_data;
  int       fail_count, pending, quiet_cycles;
  logic     draining;
  tie_in_t  program_q [$];

  toy_isa_instruction_executor dut (.*);

  tie_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] pick_reg();
    return ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
  endfunction

  // random request, mostly well-formed
  function automatic tie_in_t random_request(logic allow_ret);
    tie_in_t r;
    logic [7:0] ops [14] = '{OP_SET, OP_ADD, OP_ADDI, OP_SUB, OP_SUBI, OP_MUL,
      OP_MULI, OP_DIV, OP_DIVI, OP_LOAD, OP_LOADR, OP_STORE, OP_STORER, OP_SET};
    r.opcode       = ops[$urandom_range(0, 13)];
    if (!allow_ret && $urandom_range(0, 29) == 0) r.opcode = 8'($urandom);
    if (r.opcode == OP_RET && !allow_ret) r.opcode = OP_SET;
    r.target_index = pick_reg();
    r.field_b      = pick_reg();
    r.field_c      = pick_reg();
    case (r.opcode)
      OP_SET: begin
        r.field_b = 8'($urandom); r.field_c = 8'($urandom);
      end
      OP_ADDI, OP_SUBI, OP_MULI, OP_DIVI: r.field_c = 8'($urandom);
      OP_LOAD, OP_STORE: begin
        if ($urandom_range(0, 9) == 0) begin
          r.field_b = 8'($urandom); r.field_c = 8'($urandom);
        end else begin
          r.field_b = 8'($urandom_range(0, 15)); r.field_c = 8'($urandom);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic tie_in_t req(logic [7:0] op, logic [7:0] t, logic [7:0] b,
                                  logic [7:0] c);
    tie_in_t r;
    r.opcode = op; r.target_index = t; r.field_b = b; r.field_c = c;
    return r;
  endfunction

  // random back-pressure on results
  always @(posedge clk) begin
    int gap;
    if (!rst_n) out_ready <= 0;
    else if (out_valid && out_ready) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      out_ready <= (gap == 0);
      repeat (gap) @(posedge clk);
      out_ready <= 1;
    end else out_ready <= 1;
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT + (draining ? 0 : MEM_BYTES_DEF)) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int gap;
    rst_n = 0; in_valid = 0; in_data = '0; draining = 0;
    // directed requests
    program_q = '{
      req(OP_SET, 1, 8'hFF, 8'hFF), req(OP_SET, 2, 0, 0), req(OP_SET, 3, 0, 1),
      req(OP_SUB, 4, 2, 3), req(OP_MULI, 5, 4, 8'h80), req(OP_MUL, 5, 5, 1),
      req(OP_MUL, 5, 5, 1), req(OP_DIV, 6, 5, 4), req(OP_DIV, 7, 1, 2),
      req(OP_DIVI, 8, 4, 8'h03), req(OP_ADDI, 9, 1, 8'hFF), req(OP_ADD, 10, 4, 1),
      req(OP_STORE, 4, 8'h0F, 8'hFC), req(OP_LOAD, 11, 8'h0F, 8'hFC),
      req(OP_STORE, 4, 8'h0F, 8'hFD), req(OP_LOAD, 11, 8'hFF, 8'hFF),
      req(OP_STORER, 1, 3, 2), req(OP_LOADR, 12, 2, 3), req(OP_LOADR, 12, 4, 4),
      req(OP_SET, 16, 0, 0), req(OP_ADD, 1, 8'hFF, 0), req(OP_SUB, 1, 0, 16),
      req(8'hFF, 0, 0, 0)};
    repeat (8) @(posedge clk);
    rst_n <= 1;
    for (int i = 0; i < 1150; i++)
      program_q.push_back(random_request(0));
    program_q.push_back(req(OP_RET, 0, 0, 0));
    for (int i = 0; i < 5; i++) program_q.push_back(random_request(1));
    foreach (program_q[i]) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      // drop valid only for a real gap, so it is never driven twice in one step
      if (gap != 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1;
      in_data  <= program_q[i];
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 0;
    draining = 1;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
